### hw/rtl/pic_pkg.sv
// ============================================================================
// pic_pkg: shared types and constants for the prescaled IRQ counter
// Holds the request and response payload structs, the command and register
// codes, and the sequencer state type.
// ============================================================================
`default_nettype none

package pic_pkg;

   // Number of prescaler steps that one scanline gives.
   localparam logic [7:0] SCANLINE_STEPS = 8'd8;

   // Prescaler windows selected by mode bit 2.
   localparam logic [7:0] MASK_NARROW = 8'h07;
   localparam logic [7:0] MASK_WIDE   = 8'hFF;

   typedef enum logic [1:0] {
      CMD_REG_WRITE = 2'd0,
      CMD_CPU_BATCH = 2'd1,
      CMD_SCANLINE  = 2'd2,
      CMD_PPU_FETCH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SRC_CPU      = 2'd0,
      SRC_SCANLINE = 2'd1,
      SRC_PPU      = 2'd2,
      SRC_NONE     = 2'd3
   } src_type;

   typedef enum logic [1:0] {
      DIR_STOP0 = 2'd0,
      DIR_UP    = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_STOP3 = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      REG_ENABLE    = 3'd0,
      REG_MODE      = 3'd1,
      REG_DISABLE   = 3'd2,
      REG_ENABLE_ON = 3'd3,
      REG_PRESCALER = 3'd4,
      REG_COUNTER   = 3'd5,
      REG_XOR       = 3'd6,
      REG_UNUSED    = 3'd7
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  reg_index;
      logic [7:0]  wr_data;
      logic [7:0]  cycle_count;
      logic [13:0] ppu_addr;
   } req_type;

   typedef struct packed {
      logic       irq_out;
      logic [7:0] count_value;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/prescaled_irq_counter.sv
// A request that gives no prescaler steps goes from ST_IDLE to ST_DONE; one that
// gives N steps runs them in ST_STEP first. The response is registered from ST_DONE.
// The block takes no new request until the response leaves ST_DONE; the single
// prescaler step unit handles one step per cycle.
// A finished response waits in an output register while the next request is taken.
// Reset is synchronous and active high and clears all timer state and handshakes.
// ============================================================================
// prescaled_irq_counter: cartridge interrupt timer with a prescaler
// Takes register writes and clock events, steps a 3-bit or 8-bit prescaler
// one step per cycle, and reports the interrupt level and the main count.
// ============================================================================
`default_nettype none

module prescaled_irq_counter
   import pic_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   // Timer state.
   logic [7:0]  mode_ff,    mode_in;
   logic [7:0]  pre_ff,     pre_in;
   logic [7:0]  count_ff,   count_in;
   logic [7:0]  xor_ff,     xor_in;
   logic        enable_ff,  enable_in;
   logic        pending_ff, pending_in;
   logic [13:0] fetch_ff,   fetch_in;

   // Sequencer: state and the number of prescaler steps still to run.
   state_type   state_ff,   state_in;
   logic [7:0]  steps_ff,   steps_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff,       rsp_in;

   // Shared step unit outputs.
   dir_type     dir;
   logic [7:0]  mask;
   logic [7:0]  step_pre;
   logic        step_wrap;
   logic [7:0]  step_count;
   logic        step_irq;

   logic        req_take;
   logic [7:0]  load_steps;
   logic        rsp_free;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // The single step unit: one prescaler step, with the carry into the main
   // counter and the interrupt check. Mode is stable while steps run because
   // the block takes no write in that time.
   always_comb begin
      dir  = dir_type'(mode_ff[7:6]);
      mask = mode_ff[2] ? MASK_NARROW : MASK_WIDE;
      step_pre   = pre_ff;
      step_wrap  = 1'b0;
      step_count = count_ff;
      step_irq   = 1'b0;
      case (dir)
         DIR_UP: begin
            step_pre  = pre_ff + 8'd1;
            step_wrap = ((step_pre & mask) == 8'h00);
            if (step_wrap) begin
               step_count = count_ff + 8'd1;
               step_irq   = (step_count == 8'h00) && enable_ff;
            end
         end
         DIR_DOWN: begin
            step_pre  = pre_ff - 8'd1;
            step_wrap = ((step_pre & mask) == mask);
            if (step_wrap) begin
               step_count = count_ff - 8'd1;
               step_irq   = (step_count == 8'hFF) && enable_ff;
            end
         end
         default: begin
            step_pre = pre_ff;
         end
      endcase
   end

   // Sequencer next state and timer updates.
   always_comb begin
      mode_in      = mode_ff;
      pre_in       = pre_ff;
      count_in     = count_ff;
      xor_in       = xor_ff;
      enable_in    = enable_ff;
      pending_in   = pending_ff;
      fetch_in     = fetch_ff;
      state_in     = state_ff;
      steps_in     = steps_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      load_steps   = 8'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (cmd_type'(req_payload.cmd))
                  CMD_REG_WRITE: begin
                     case (reg_type'(req_payload.reg_index))
                        REG_ENABLE: begin
                           enable_in = req_payload.wr_data[0];
                           if (!req_payload.wr_data[0]) begin
                              pending_in = 1'b0;
                           end
                        end
                        REG_MODE:      mode_in = req_payload.wr_data;
                        REG_DISABLE: begin
                           enable_in  = 1'b0;
                           pending_in = 1'b0;
                        end
                        REG_ENABLE_ON: enable_in = 1'b1;
                        REG_PRESCALER: pre_in    = req_payload.wr_data ^ xor_ff;
                        REG_COUNTER:   count_in  = req_payload.wr_data ^ xor_ff;
                        REG_XOR:       xor_in    = req_payload.wr_data;
                        default:       mode_in   = mode_ff;
                     endcase
                  end
                  CMD_CPU_BATCH: begin
                     if (src_type'(mode_ff[1:0]) == SRC_CPU) begin
                        load_steps = req_payload.cycle_count;
                     end
                  end
                  CMD_SCANLINE: begin
                     if (src_type'(mode_ff[1:0]) == SRC_SCANLINE) begin
                        load_steps = SCANLINE_STEPS;
                     end
                  end
                  default: begin
                     if (src_type'(mode_ff[1:0]) == SRC_PPU) begin
                        if (fetch_ff != req_payload.ppu_addr) begin
                           load_steps = 8'd2;
                        end
                        fetch_in = req_payload.ppu_addr;
                     end
                  end
               endcase
               // With the count stopped a step changes nothing, so skip it.
               if (load_steps != 8'd0 && (dir == DIR_UP || dir == DIR_DOWN)) begin
                  steps_in = load_steps;
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_STEP: begin
            pre_in   = step_pre;
            count_in = step_count;
            if (step_irq) begin
               pending_in = 1'b1;
            end
            steps_in = steps_ff - 8'd1;
            if (steps_ff == 8'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in.irq_out     = pending_ff;
               rsp_in.count_value = count_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 8'h00;
         pre_ff       <= 8'h00;
         count_ff     <= 8'h00;
         xor_ff       <= 8'h00;
         enable_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         fetch_ff     <= 14'h0000;
         state_ff     <= ST_IDLE;
         steps_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pre_ff       <= pre_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         enable_ff    <= enable_in;
         pending_ff   <= pending_in;
         fetch_ff     <= fetch_in;
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // The step loop never runs with an exhausted count.
   a_steps_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> steps_ff != 8'd0)
      else $error("step state entered with zero steps left");

   // The last step always hands over to the response state.
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP && steps_ff == 8'd1 |=> state_ff == ST_DONE)
      else $error("last step did not finish the request");

   // An interrupt can only latch while the timer is enabled.
   a_irq_enabled: assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff) |-> $past(enable_ff))
      else $error("interrupt latched while timer disabled");

   // A response held under stall is not overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && state_ff == ST_DONE |=> state_ff == ST_DONE)
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire
